@@ sv/urlpd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the URL percent decoder: character codes, escape phase codes,
// the result count type and the hex digit decode. No dependencies.
package urlpd_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CTRL_LIM = 8'h20;

    // escape phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    localparam int MAX_RES = 3;

    typedef logic [1:0] res_cnt_t;

    // bit 4 set when the character is not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

@@ sv/url_percent_decoder.sv @@
`timescale 1ns / 1ps
// Latency: a result is registered and appears in the cycle after the request that caused it.
// Throughput: one request per cycle while each yields at most one byte and m_tready
// is high; a request that yields two or three bytes holds s_tready low while the
// result buffer drains one byte per cycle, as long as m_tready is high.
// Reset (rst_n low, asynchronous): no escape pending, result buffer empty.
// Streaming URL percent decoder; uses urlpd_pkg.
module url_percent_decoder
    import urlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    logic [1:0]      phase_reg, phase_next;
    logic [7:0]      held_reg, held_next;
    logic [7:0]      res_reg [MAX_RES];
    logic [7:0]      res_next [MAX_RES];
    res_cnt_t        rem_reg, n_next;
    logic [1:0]      ptr_reg;
    logic            last_reg;
    logic            in_acc, out_acc;

    assign m_tvalid = (rem_reg != 2'd0);
    assign m_tdata  = res_reg[ptr_reg];
    assign m_tlast  = last_reg && (rem_reg == 2'd1);
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_tready);
    assign in_acc   = s_tvalid && s_tready;

    always_comb
    begin
        logic [4:0] v;
        logic [4:0] hv;
        logic [7:0] d;
        logic       p_emit;
        logic [7:0] p_byte;
        logic       p_hold;

        v = hex_val(s_tdata);
        hv = hex_val(held_reg);
        d = {hv[3:0], v[3:0]};
        if (d < CTRL_LIM || d == CH_DEL)
        begin
            d = CH_UNDER;
        end

        // plain handling of the new byte with nothing pending
        p_emit = 1'b1;
        p_byte = s_tdata;
        p_hold = 1'b0;
        if (s_tdata == CH_PLUS)
        begin
            p_byte = CH_SPACE;
        end
        else if (s_tdata == CH_PCT && !s_tlast)
        begin
            p_emit = 1'b0;
            p_hold = 1'b1;
        end

        res_next[0] = p_byte;
        res_next[1] = p_byte;
        res_next[2] = p_byte;
        held_next   = held_reg;
        phase_next  = p_hold ? PH_PCT : PH_IDLE;
        n_next      = {1'b0, p_emit};

        unique case (phase_reg)
            PH_PCT:
            begin
                if (!v[4])
                begin
                    res_next[0] = CH_PCT;
                    res_next[1] = s_tdata;
                    if (s_tlast)
                    begin
                        n_next     = 2'd2;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        n_next     = 2'd0;
                        held_next  = s_tdata;
                        phase_next = PH_DIGIT;
                    end
                end
                else
                begin
                    res_next[0] = CH_PCT;
                    n_next      = p_emit ? 2'd2 : 2'd1;
                end
            end
            PH_DIGIT:
            begin
                if (!v[4])
                begin
                    res_next[0] = d;
                    n_next      = 2'd1;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    res_next[0] = CH_PCT;
                    res_next[1] = held_reg;
                    n_next      = p_emit ? 2'd3 : 2'd2;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
            rem_reg   <= 2'd0;
            ptr_reg   <= 2'd0;
            last_reg  <= 1'b0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            rem_reg   <= n_next;
            ptr_reg   <= 2'd0;
            last_reg  <= s_tlast;
        end
        else if (out_acc)
        begin
            // advance to the next buffered byte
            rem_reg <= rem_reg - 2'd1;
            ptr_reg <= ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_reg <= res_next;
        end
    end

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> rem_reg <= 2'd1)
        else $error("request taken while result buffer still holds bytes");

    a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> phase_reg == PH_IDLE)
        else $error("escape still pending after final request");

    a_last_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("final request produced no result");

    a_tlast_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (rem_reg == 2'd1 && last_reg))
        else $error("out_last raised before the last buffered byte");

endmodule
